FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; clk and rst_n must exist where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CHK_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

FILE: src/gdd_pkg.sv
// Shared types, constants and calendar helpers for the day difference block.
// No dependencies; used by every module of the block.
package gdd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 23;
    localparam int ACC_W   = 24;
    localparam int RES_W   = 9;
    localparam int OFF_W   = 9;
    localparam int SUB_W   = 10;

    localparam logic [YEAR_W-1:0] MAX_YEAR  = 14'd9999;
    localparam logic [RES_W-1:0]  ERA_YEARS = 9'd400;
    localparam logic [RES_W-1:0]  LAST_RES  = 9'd399;
    localparam logic [RES_W-1:0]  CENT_1    = 9'd100;
    localparam logic [RES_W-1:0]  CENT_2    = 9'd200;
    localparam logic [RES_W-1:0]  CENT_3    = 9'd300;
    localparam logic [ACC_W-1:0]  YEAR_DAYS = 24'd365;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_B,
        ST_CHECK,
        ST_SUB,
        ST_WALK,
        ST_INCL,
        ST_NEG,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        DP_HOLD,
        DP_LOAD,
        DP_RED_STEP,
        DP_RED_A_END,
        DP_RED_B_END,
        DP_SETUP,
        DP_SUB,
        DP_WALK,
        DP_INCL,
        DP_NEG
    } dp_op_t;

    typedef enum logic [2:0] {
        ALU_ERA,
        ALU_SUB,
        ALU_WALK,
        ALU_INCL,
        ALU_NEG
    } alu_sel_t;

    typedef struct packed {
        dp_op_t   op;
        alu_sel_t alu_sel;
        logic     out_load;
        logic     in_ready;
    } ctrl_t;

    typedef struct packed {
        logic era_ge;
        logic date_bad;
        logic walk_end;
    } stat_t;

    // Leap test on a year taken modulo 400
    function automatic logic is_leap(input logic [RES_W-1:0] res);
        is_leap = (res == '0) ||
                  ((res[1:0] == 2'b00) && (res != CENT_1) && (res != CENT_2) &&
                   (res != CENT_3));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        month_len = len;
    endfunction

    // Days from March 1 to the first of the month, in a March-based year
    function automatic logic [OFF_W-1:0] mar_offset(input logic [MONTH_W-1:0] m);
        logic [OFF_W-1:0] off;
        unique case (m)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        mar_offset = off;
    endfunction

    function automatic logic date_ok(input logic [YEAR_W-1:0] y,
                                     input logic [MONTH_W-1:0] m,
                                     input logic [DAY_W-1:0] d,
                                     input logic leap);
        date_ok = (y != '0) && (y <= MAX_YEAR) && (m != '0) && (m <= MONTH_DEC) &&
                  (d != '0) && (d <= month_len(m, leap));
    endfunction

endpackage

FILE: src/gdd_alu.sv
// Shared adder of the day difference block: a + b + carry-in.
// Depends on gdd_pkg for the accumulator width.
module gdd_alu (
    input  logic [gdd_pkg::ACC_W-1:0] a,
    input  logic [gdd_pkg::ACC_W-1:0] b,
    input  logic                      cin,
    output logic [gdd_pkg::ACC_W-1:0] sum
);
    import gdd_pkg::*;

    // Add both operands and the carry
    assign sum = a + b + ACC_W'(cin);

endmodule

FILE: src/gdd_fsm.sv
// Sequencer of the day difference block: steps the datapath through
// year reduction, validation, offset subtraction, year walk, end inclusion and sign fix.
// Depends on gdd_pkg.
module gdd_fsm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           out_free,
    input  gdd_pkg::stat_t stat,
    output gdd_pkg::ctrl_t ctrl
);
    import gdd_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the current step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the step
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_RED_A;
            ST_RED_A: if (!stat.era_ge) state_next = ST_RED_B;
            ST_RED_B: if (!stat.era_ge) state_next = ST_CHECK;
            ST_CHECK: state_next = stat.date_bad ? ST_DONE : ST_SUB;
            ST_SUB:   state_next = ST_WALK;
            ST_WALK:  if (stat.walk_end) state_next = ST_INCL;
            ST_INCL:  state_next = ST_NEG;
            ST_NEG:   state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Drive datapath controls
    always_comb
    begin
        ctrl = '{op: DP_HOLD, alu_sel: ALU_ERA, out_load: 1'b0, in_ready: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (in_valid) ctrl.op = DP_LOAD;
            end
            ST_RED_A: ctrl.op = stat.era_ge ? DP_RED_STEP : DP_RED_A_END;
            ST_RED_B: ctrl.op = stat.era_ge ? DP_RED_STEP : DP_RED_B_END;
            ST_CHECK: ctrl.op = DP_SETUP;
            ST_SUB:
            begin
                ctrl.op      = DP_SUB;
                ctrl.alu_sel = ALU_SUB;
            end
            ST_WALK:
            begin
                ctrl.alu_sel = ALU_WALK;
                if (!stat.walk_end) ctrl.op = DP_WALK;
            end
            ST_INCL:
            begin
                ctrl.op      = DP_INCL;
                ctrl.alu_sel = ALU_INCL;
            end
            ST_NEG:
            begin
                ctrl.op      = DP_NEG;
                ctrl.alu_sel = ALU_NEG;
            end
            ST_DONE:  ctrl.out_load = out_free;
            default:  ctrl.op = DP_HOLD;
        endcase
    end

endmodule

FILE: src/gdd_dp.sv
// Datapath of the day difference block: request registers, year residues,
// day accumulator and year walk counter around one shared adder.
// Depends on gdd_pkg and gdd_alu.
module gdd_dp (
    input  logic                        clk,
    input  gdd_pkg::ctrl_t              ctrl,
    input  logic [gdd_pkg::YEAR_W-1:0]  first_year,
    input  logic [gdd_pkg::MONTH_W-1:0] first_month,
    input  logic [gdd_pkg::DAY_W-1:0]   first_day,
    input  logic [gdd_pkg::YEAR_W-1:0]  second_year,
    input  logic [gdd_pkg::MONTH_W-1:0] second_month,
    input  logic [gdd_pkg::DAY_W-1:0]   second_day,
    input  logic                        include_end,
    output gdd_pkg::stat_t              stat,
    output logic [gdd_pkg::COUNT_W-1:0] count,
    output logic                        bad
);
    import gdd_pkg::*;

    logic [YEAR_W-1:0]  y1_reg, y2_reg, yred_reg, cnt_reg, hi_reg;
    logic [YEAR_W-1:0]  yred_next, cnt_next, hi_next;
    logic [MONTH_W-1:0] m1_reg, m2_reg;
    logic [DAY_W-1:0]   d1_reg, d2_reg;
    logic               incl_reg, swap_reg, bad_reg;
    logic               swap_next, bad_next;
    logic [RES_W-1:0]   r1_reg, r2_reg, res_reg;
    logic [RES_W-1:0]   r1_next, r2_next, res_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [SUB_W-1:0]   sub_reg, sub_next;

    logic [ACC_W-1:0]   alu_a, alu_b, alu_sum;
    logic               alu_cin;

    logic [YEAR_W-1:0]  y_lo, y_hi;
    logic [MONTH_W-1:0] m_lo, m_hi;
    logic [DAY_W-1:0]   d_lo, d_hi;
    logic [RES_W-1:0]   r_lo, r_lo_inc, res_init;
    logic               swap_now, early_lo, early_hi, bad_now;
    logic [ACC_W-1:0]   acc_init;

    gdd_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .cin (alu_cin),
        .sum (alu_sum)
    );

    // Select adder operands
    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = '0;
        alu_cin = 1'b0;
        unique case (ctrl.alu_sel)
            ALU_ERA:
            begin
                alu_a   = ACC_W'(yred_reg);
                alu_b   = ~ACC_W'(ERA_YEARS);
                alu_cin = 1'b1;
            end
            ALU_SUB:
            begin
                alu_b   = ~ACC_W'(sub_reg);
                alu_cin = 1'b1;
            end
            ALU_WALK:
            begin
                alu_b   = YEAR_DAYS;
                alu_cin = is_leap(res_reg);
            end
            ALU_INCL: alu_cin = incl_reg;
            ALU_NEG:
            begin
                alu_a   = swap_reg ? ~acc_reg : acc_reg;
                alu_cin = swap_reg;
            end
            default:  alu_cin = 1'b0;
        endcase
    end

    // Order the dates and pick the earlier one as the walk start
    always_comb
    begin
        swap_now = !({y1_reg, m1_reg, d1_reg} < {y2_reg, m2_reg, d2_reg});
        y_lo     = swap_now ? y2_reg : y1_reg;
        m_lo     = swap_now ? m2_reg : m1_reg;
        d_lo     = swap_now ? d2_reg : d1_reg;
        r_lo     = swap_now ? r2_reg : r1_reg;
        y_hi     = swap_now ? y1_reg : y2_reg;
        m_hi     = swap_now ? m1_reg : m2_reg;
        d_hi     = swap_now ? d1_reg : d2_reg;
        early_lo = (m_lo <= MONTH_FEB);
        early_hi = (m_hi <= MONTH_FEB);
        r_lo_inc = (r_lo == LAST_RES) ? '0 : r_lo + 1'b1;
        res_init = early_lo ? r_lo : r_lo_inc;
        acc_init = ACC_W'(mar_offset(m_hi)) + ACC_W'(d_hi);
        bad_now  = !date_ok(y1_reg, m1_reg, d1_reg, is_leap(r1_reg)) ||
                   !date_ok(y2_reg, m2_reg, d2_reg, is_leap(r2_reg));
    end

    // Compute register updates for the current step
    always_comb
    begin
        yred_next = yred_reg;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        swap_next = swap_reg;
        bad_next  = bad_reg;
        r1_next   = r1_reg;
        r2_next   = r2_reg;
        res_next  = res_reg;
        acc_next  = acc_reg;
        sub_next  = sub_reg;
        unique case (ctrl.op)
            DP_HOLD:      acc_next = acc_reg;
            DP_LOAD:      yred_next = first_year;
            DP_RED_STEP:  yred_next = alu_sum[YEAR_W-1:0];
            DP_RED_A_END:
            begin
                r1_next   = yred_reg[RES_W-1:0];
                yred_next = y2_reg;
            end
            DP_RED_B_END: r2_next = yred_reg[RES_W-1:0];
            DP_SETUP:
            begin
                swap_next = swap_now;
                bad_next  = bad_now;
                cnt_next  = y_lo - YEAR_W'(early_lo);
                hi_next   = y_hi - YEAR_W'(early_hi);
                res_next  = res_init;
                sub_next  = SUB_W'(mar_offset(m_lo)) + SUB_W'(d_lo);
                acc_next  = bad_now ? '0 : acc_init;
            end
            DP_SUB:       acc_next = alu_sum;
            DP_WALK:
            begin
                acc_next = alu_sum;
                cnt_next = cnt_reg + 1'b1;
                res_next = (res_reg == LAST_RES) ? '0 : res_reg + 1'b1;
            end
            DP_INCL:      acc_next = alu_sum;
            DP_NEG:       acc_next = alu_sum;
            default:      acc_next = acc_reg;
        endcase
    end

    // Hold request fields and working values
    always_ff @(posedge clk)
    begin
        if (ctrl.op == DP_LOAD)
        begin
            y1_reg   <= first_year;
            m1_reg   <= first_month;
            d1_reg   <= first_day;
            y2_reg   <= second_year;
            m2_reg   <= second_month;
            d2_reg   <= second_day;
            incl_reg <= include_end;
        end
        yred_reg <= yred_next;
        cnt_reg  <= cnt_next;
        hi_reg   <= hi_next;
        swap_reg <= swap_next;
        bad_reg  <= bad_next;
        r1_reg   <= r1_next;
        r2_reg   <= r2_next;
        res_reg  <= res_next;
        acc_reg  <= acc_next;
        sub_reg  <= sub_next;
    end

    // Report status to the sequencer
    assign stat.era_ge   = !alu_sum[ACC_W-1];
    assign stat.date_bad = bad_now;
    assign stat.walk_end = (cnt_reg == hi_reg);

    assign count = acc_reg[COUNT_W-1:0];
    assign bad   = bad_reg;

endmodule

FILE: src/gregorian_day_difference.sv
// Top level of the Gregorian day difference block: sequencer, datapath and
// result register. Depends on gdd_pkg, gdd_fsm, gdd_dp.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_ready | first_year/month/day, second_year/month/day,
//          |                     | include_end
//  out     | out_valid/out_ready | day_count, invalid_date
//
// A new request is taken only once the last one has reached the output register;
//   the reduction steps down 400 years at a time and the walk adds one year at a
//   time through the shared adder. A request with a bad date skips the subtraction,
//   walk, end inclusion and sign steps.
// in_ready is high only while the sequencer is idle.
// A finished result waits in the output register; the next request is taken
//   while it waits, and the sequencer stalls at its end only if it is still full.
// Reset clears the sequencer and the output valid flag.
module gregorian_day_difference (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gdd_pkg::YEAR_W-1:0]  first_year,
    input  logic [gdd_pkg::MONTH_W-1:0] first_month,
    input  logic [gdd_pkg::DAY_W-1:0]   first_day,
    input  logic [gdd_pkg::YEAR_W-1:0]  second_year,
    input  logic [gdd_pkg::MONTH_W-1:0] second_month,
    input  logic [gdd_pkg::DAY_W-1:0]   second_day,
    input  logic                        include_end,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gdd_pkg::COUNT_W-1:0] day_count,
    output logic                        invalid_date
);
    import gdd_pkg::*;

    ctrl_t              ctrl;
    stat_t              stat;
    logic [COUNT_W-1:0] count;
    logic               bad;
    logic               out_free;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] day_count_reg;
    logic               invalid_reg;

    assign out_free = !out_valid_reg || out_ready;

    gdd_fsm u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    gdd_dp u_dp (
        .clk          (clk),
        .ctrl         (ctrl),
        .first_year   (first_year),
        .first_month  (first_month),
        .first_day    (first_day),
        .second_year  (second_year),
        .second_month (second_month),
        .second_day   (second_day),
        .include_end  (include_end),
        .stat         (stat),
        .count        (count),
        .bad          (bad)
    );

    // Track output occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the finished result
    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            day_count_reg <= count;
            invalid_reg   <= bad;
        end
    end

    assign in_ready     = ctrl.in_ready;
    assign out_valid    = out_valid_reg;
    assign day_count    = day_count_reg;
    assign invalid_date = invalid_reg;

endmodule

FILE: src/gdd_checker.sv
// Port-level checks for the Gregorian day difference block, bound to the top.
// Depends on gdd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gdd_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [gdd_pkg::COUNT_W-1:0] day_count,
    input  logic                        invalid_date
);
    import gdd_pkg::*;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 23'sd3652060;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = -23'sd3652060;

    // An invalid request reports a zero count
    `CHK_NOW(a_invalid_zero, out_valid && invalid_date, day_count == '0)

    // A taken request keeps the block busy in the next cycle
    `CHK_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

    // A stalled result holds
    `CHK_NEXT(a_out_hold, out_valid && !out_ready,
              out_valid && $stable(day_count) && $stable(invalid_date))

    // The count stays within the span of the calendar
    `CHK_NOW(a_count_range, out_valid,
             ($signed(day_count) <= COUNT_MAX) && ($signed(day_count) >= COUNT_MIN))

endmodule

bind gregorian_day_difference gdd_checker u_gdd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .day_count    (day_count),
    .invalid_date (invalid_date)
);
